>>> hdl/hev_pkg.sv
`default_nettype none
package hev_pkg;

  localparam int DATA_W  = 57;
  localparam int LEN_W   = 6;
  localparam int PAR_W   = 3;
  localparam int CHUNK_W = 8;
  localparam int MAX_R   = 7;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4);

  typedef struct packed {
    logic [LEN_W-1:0] code_length;
    logic [PAR_W-1:0] parity_count;
  } len_info_t;

  function automatic logic [PAR_W-1:0] parity_for(input logic [LEN_W-1:0] len);
    logic [PAR_W-1:0] r;
    logic             found;
    r     = '0;
    found = 1'b0;
    for (int i = 0; i < MAX_R; i++) begin
      if (!found && ((32'd1 << i) >= (32'(len) + 32'(i) + 32'd1))) begin
        r     = PAR_W'(i);
        found = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic int largest_length(input int max_bits);
    int len;
    int top;
    int r;
    top = 1;
    for (len = 2; len <= max_bits; len++) begin
      r = 0;
      while ((1 << r) < (len + r + 1)) r++;
      if (len + r <= max_bits) top = len;
    end
    return top;
  endfunction

endpackage
`default_nettype wire

>>> hdl/hev_front.sv
`default_nettype none
module hev_front #(
  parameter int MAX_CODE_BITS = 63
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic                          ready_i,
  input  wire logic [hev_pkg::LEN_W-1:0]     data_length,
  input  wire logic [hev_pkg::DATA_W-1:0]    data_word,
  output logic                               valid_o,
  output logic [hev_pkg::DATA_W-1:0]         data_o,
  output hev_pkg::len_info_t                 info_o
);

  localparam logic [hev_pkg::LEN_W-1:0] TOP_LEN =
    hev_pkg::LEN_W'(hev_pkg::largest_length(MAX_CODE_BITS));

  logic                            valid_r;
  logic [hev_pkg::DATA_W-1:0]      data_r;
  logic [hev_pkg::DATA_W-1:0]      data_nxt;
  hev_pkg::len_info_t              info_r;
  hev_pkg::len_info_t              info_nxt;
  logic [hev_pkg::LEN_W-1:0]       len_eff;
  logic [hev_pkg::PAR_W-1:0]       r_eff;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    if (data_length == '0) begin
      len_eff = hev_pkg::LEN_W'(1);
    end else if (data_length > TOP_LEN) begin
      len_eff = TOP_LEN;
    end else begin
      len_eff = data_length;
    end
    r_eff                 = hev_pkg::parity_for(len_eff);
    info_nxt.parity_count = r_eff;
    info_nxt.code_length  = len_eff + hev_pkg::LEN_W'(r_eff);
    for (int i = 0; i < hev_pkg::DATA_W; i++) begin
      data_nxt[i] = data_word[i] && (hev_pkg::LEN_W'(i) < len_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
      info_r <= info_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;
  assign info_o  = info_r;

endmodule
`default_nettype wire

>>> hdl/hev_place.sv
`default_nettype none
module hev_place #(
  parameter int CODE_W = 63,
  localparam int PW = $clog2(CODE_W + 1),
  localparam int NC = (CODE_W + hev_pkg::CHUNK_W - 1) / hev_pkg::CHUNK_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic                          ready_i,
  input  wire logic [hev_pkg::DATA_W-1:0]    data_i,
  input  wire hev_pkg::len_info_t            info_i,
  output logic                               valid_o,
  output logic [CODE_W-1:0]                  cw_o,
  output logic [PW-1:0][NC-1:0]              chunk_o,
  output hev_pkg::len_info_t                 info_o
);

  logic                    valid_r;
  logic [CODE_W-1:0]       cw_r;
  logic [CODE_W-1:0]       cw_nxt;
  logic [PW-1:0][NC-1:0]   chunk_r;
  logic [PW-1:0][NC-1:0]   chunk_nxt;
  hev_pkg::len_info_t      info_r;

  assign ready_o = !valid_r || ready_i;

  for (genvar j = 1; j <= CODE_W; j++) begin : g_pos
    localparam int IDX = j - $clog2(j + 1) - 1;
    if (((j & (j - 1)) == 0) || (IDX >= hev_pkg::DATA_W)) begin : g_zero
      assign cw_nxt[j-1] = 1'b0;
    end else begin : g_data
      assign cw_nxt[j-1] = data_i[IDX];
    end
  end

  always_comb begin
    int  pos;
    logic acc;
    for (int k = 0; k < PW; k++) begin
      for (int c = 0; c < NC; c++) begin
        acc = 1'b0;
        for (int b = 0; b < hev_pkg::CHUNK_W; b++) begin
          pos = c * hev_pkg::CHUNK_W + b + 1;
          if ((pos <= CODE_W) && (((pos >> k) & 1) == 1)) begin
            acc = acc ^ cw_nxt[pos-1];
          end
        end
        chunk_nxt[k][c] = acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      cw_r    <= cw_nxt;
      chunk_r <= chunk_nxt;
      info_r  <= info_i;
    end
  end

  assign valid_o = valid_r;
  assign cw_o    = cw_r;
  assign chunk_o = chunk_r;
  assign info_o  = info_r;

endmodule
`default_nettype wire

>>> hdl/hev_parity.sv
`default_nettype none
module hev_parity #(
  parameter int CODE_W = 63,
  localparam int PW = $clog2(CODE_W + 1),
  localparam int NC = (CODE_W + hev_pkg::CHUNK_W - 1) / hev_pkg::CHUNK_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   valid_i,
  output logic                        ready_o,
  input  wire logic                   ready_i,
  input  wire logic [CODE_W-1:0]      cw_i,
  input  wire logic [PW-1:0][NC-1:0]  chunk_i,
  input  wire hev_pkg::len_info_t     info_i,
  output logic                        valid_o,
  output logic [CODE_W-1:0]           cw_o,
  output hev_pkg::len_info_t          info_o
);

  logic                 valid_r;
  logic [CODE_W-1:0]    cw_r;
  logic [CODE_W-1:0]    cw_nxt;
  hev_pkg::len_info_t   info_r;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    cw_nxt = cw_i;
    for (int k = 0; k < PW; k++) begin
      cw_nxt[(1 << k) - 1] = ^chunk_i[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      cw_r   <= cw_nxt;
      info_r <= info_i;
    end
  end

  assign valid_o = valid_r;
  assign cw_o    = cw_r;
  assign info_o  = info_r;

endmodule
`default_nettype wire

>>> hdl/hamming_encoder_variable_length.sv
// Channel  | Direction | Ports                                             | Handshake
// ---------+-----------+---------------------------------------------------+--------------
// input    | in        | in_valid, in_stall, in_data_word                  | valid / stall
// result   | out       | out_valid, out_stall, out_code_word,              | valid / stall
//          |           | out_code_length, out_parity_count                 |
// config   | in        | cfg_wr_en, cfg_wr_data                            | write enable
//
// One word per cycle sustained while out_stall stays low; a result is registered in the front,
// placement and parity stages in turn, and out_valid rises once the parity stage holds it.
// Stages: length clamp and data mask, bit placement with partial group XORs, parity insert.
// Each stage holds its own valid bit; a stall backs up only as far as the first empty stage.
// Synchronous reset empties the pipeline and loads data_length with 4.
`default_nettype none
module hamming_encoder_variable_length #(
  parameter int MAX_CODE_BITS = 63
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [hev_pkg::LEN_W-1:0]     cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [hev_pkg::DATA_W-1:0]    in_data_word,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [MAX_CODE_BITS-1:0]           out_code_word,
  output logic [hev_pkg::LEN_W-1:0]          out_code_length,
  output logic [hev_pkg::PAR_W-1:0]          out_parity_count
);

  localparam int PW = $clog2(MAX_CODE_BITS + 1);
  localparam int NC = (MAX_CODE_BITS + hev_pkg::CHUNK_W - 1) / hev_pkg::CHUNK_W;

  logic [hev_pkg::LEN_W-1:0]   data_length_r;

  logic                        s1_ready;
  logic                        s1_valid;
  logic [hev_pkg::DATA_W-1:0]  s1_data;
  hev_pkg::len_info_t          s1_info;

  logic                        s2_ready;
  logic                        s2_valid;
  logic [MAX_CODE_BITS-1:0]    s2_cw;
  logic [PW-1:0][NC-1:0]       s2_chunk;
  hev_pkg::len_info_t          s2_info;

  logic                        s3_ready;
  hev_pkg::len_info_t          s3_info;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_length_r <= hev_pkg::LEN_RESET;
    end else if (cfg_wr_en) begin
      data_length_r <= cfg_wr_data;
    end
  end

  hev_front #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_i     (in_valid),
    .ready_o     (s1_ready),
    .ready_i     (s2_ready),
    .data_length (data_length_r),
    .data_word   (in_data_word),
    .valid_o     (s1_valid),
    .data_o      (s1_data),
    .info_o      (s1_info)
  );

  hev_place #(
    .CODE_W (MAX_CODE_BITS)
  ) u_place (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .ready_i (s3_ready),
    .data_i  (s1_data),
    .info_i  (s1_info),
    .valid_o (s2_valid),
    .cw_o    (s2_cw),
    .chunk_o (s2_chunk),
    .info_o  (s2_info)
  );

  hev_parity #(
    .CODE_W (MAX_CODE_BITS)
  ) u_parity (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s2_valid),
    .ready_o (s3_ready),
    .ready_i (!out_stall),
    .cw_i    (s2_cw),
    .chunk_i (s2_chunk),
    .info_i  (s2_info),
    .valid_o (out_valid),
    .cw_o    (out_code_word),
    .info_o  (s3_info)
  );

  assign in_stall         = !s1_ready;
  assign out_code_length  = s3_info.code_length;
  assign out_parity_count = s3_info.parity_count;

endmodule
`default_nettype wire

>>> hdl/hev_checker.sv
`default_nettype none
module hev_checker #(
  parameter int MAX_CODE_BITS = 63
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [MAX_CODE_BITS-1:0]      out_code_word,
  input wire logic [hev_pkg::LEN_W-1:0]     out_code_length,
  input wire logic [hev_pkg::PAR_W-1:0]     out_parity_count
);

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled transaction dropped");

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##3 out_valid)
    else $error("accepted transaction not delivered within three cycles");

  a_upper_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_code_word >> out_code_length) == '0))
    else $error("code word bits set above code length");

  a_parity_min : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((7'd1 << out_parity_count) > 7'(out_code_length)) &&
                  ((7'd1 << (out_parity_count - 3'd1)) < 7'(out_code_length)))
    else $error("parity count not the least that covers the code length");

endmodule

bind hamming_encoder_variable_length hev_checker #(
  .MAX_CODE_BITS (MAX_CODE_BITS)
) u_hev_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_code_word    (out_code_word),
  .out_code_length  (out_code_length),
  .out_parity_count (out_parity_count)
);
`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W = hev_pkg::DATA_W;
  localparam int LEN_W  = hev_pkg::LEN_W;
  localparam int PAR_W  = hev_pkg::PAR_W;

  localparam int CODE_W   = 63;
  localparam int SEGMENTS = 20;
  localparam int SEG_ITEMS = 55;

  localparam logic [LEN_W-1:0] LEN_ZERO   = LEN_W'(0);
  localparam logic [LEN_W-1:0] LEN_MIN    = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_FIT    = LEN_W'(57);
  localparam logic [LEN_W-1:0] LEN_BEYOND = LEN_W'(58);
  localparam logic [LEN_W-1:0] LEN_FULL   = LEN_W'(63);

  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

  typedef struct packed {
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
    logic [PAR_W-1:0]  parity_count;
  } codeword_t;

  class codeword_checker;
    logic [LEN_W-1:0] data_length;
    int               longest;
    codeword_t        expected_codewords[$];
    int               mismatches;

    function new();
      data_length = hev_pkg::LEN_RESET;
      mismatches  = 0;
      longest     = CODE_W;
      while (longest > 1 && longest + parity_bits(longest) > CODE_W) longest--;
    endfunction

    function int parity_bits(int len);
      int r;
      r = 0;
      while ((1 << r) < len + r + 1) r++;
      return r;
    endfunction

    function void set_length(logic [LEN_W-1:0] len);
      data_length = len;
    endfunction

    function codeword_t encode_word(logic [DATA_W-1:0] word);
      codeword_t c;
      int len, r, n, d, j, k, p;
      logic par;
      len = int'(data_length);
      if (len < 1) len = 1;
      if (len > longest) len = longest;
      r = parity_bits(len);
      n = len + r;
      c.code_word = '0;
      d = len;
      for (j = n; j >= 1; j--) begin
        if ((j & (j - 1)) != 0) begin
          d--;
          c.code_word[j-1] = word[d];
        end
      end
      for (k = 0; k < r; k++) begin
        p = 1 << k;
        par = 1'b0;
        for (j = 1; j <= n; j++) begin
          if ((j & p) != 0) par = par ^ c.code_word[j-1];
        end
        c.code_word[p-1] = par;
      end
      c.code_length  = LEN_W'(n);
      c.parity_count = PAR_W'(r);
      return c;
    endfunction

    function void note_word(logic [DATA_W-1:0] word);
      expected_codewords.push_back(encode_word(word));
    endfunction

    function void check_result(codeword_t got);
      codeword_t want;
      if (expected_codewords.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: code_word=%h code_length=%0d parity_count=%0d",
                   got.code_word, got.code_length, got.parity_count);
        return;
      end
      want = expected_codewords.pop_front();
      if (got.code_word !== want.code_word || got.code_length !== want.code_length ||
          got.parity_count !== want.parity_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: code_word exp %h got %h, code_length exp %0d got %0d, %s%0d got %0d",
                   want.code_word, got.code_word, want.code_length, got.code_length,
                   "parity_count exp ", want.parity_count, got.parity_count);
      end
    endfunction

    function int pending();
      return expected_codewords.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [LEN_W-1:0]    cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [DATA_W-1:0]   in_data_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CODE_W-1:0]   out_code_word;
  logic [LEN_W-1:0]    out_code_length;
  logic [PAR_W-1:0]    out_parity_count;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  codeword_checker encoder_checks = new();

  hamming_encoder_variable_length #(
    .MAX_CODE_BITS(CODE_W)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_word     (in_data_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_word    (out_code_word),
    .out_code_length  (out_code_length),
    .out_parity_count (out_parity_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #500000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      encoder_checks.check_result({out_code_word, out_code_length, out_parity_count});
  end

  task automatic send_word(input logic [DATA_W-1:0] word);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_word <= word;
    // hold the transaction until the block takes it
    do @(posedge clk); while (in_stall);
    encoder_checks.note_word(word);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (encoder_checks.pending() != 0) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    encoder_checks.set_length(len);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] random_word();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return ALL_ONES;
      1: return '0;
      2: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
      default: return raw[DATA_W-1:0];
    endcase
  endfunction

  initial begin
    logic [LEN_W-1:0] seg_lengths[10];
    logic [LEN_W-1:0] len;
    int seg, i;
    seg_lengths = '{LEN_MIN, LEN_FIT, LEN_ZERO, LEN_FULL, LEN_W'(2), LEN_W'(3), LEN_W'(4),
                    LEN_W'(5), LEN_W'(11), LEN_BEYOND};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset length of four
    send_word('0);
    send_word(ALL_ONES);
    send_word(DATA_W'(4'b1011));
    send_word(DATA_W'(1) << (DATA_W - 1));
    wait_drained();

    write_length(LEN_ZERO);
    send_word(DATA_W'(1));
    send_word(ALL_ONES ^ DATA_W'(1));
    wait_drained();
    write_length(LEN_MIN);
    send_word('0);
    send_word(DATA_W'(1));
    wait_drained();
    write_length(LEN_FIT);
    send_word('0);
    send_word(ALL_ONES);
    send_word(DATA_W'(1) << (DATA_W - 1));
    send_word(DATA_W'({29{2'b01}}));
    wait_drained();
    write_length(LEN_BEYOND);
    send_word(DATA_W'({29{2'b10}}));
    send_word(DATA_W'(1));
    wait_drained();
    write_length(LEN_FULL);
    send_word(ALL_ONES);
    send_word(DATA_W'(1) << 20);
    wait_drained();
    write_length(LEN_W'(26));
    send_word(ALL_ONES);
    send_word(DATA_W'(1) << 25);
    wait_drained();

    for (seg = 0; seg < SEGMENTS; seg++) begin
      len = (seg < 10) ? seg_lengths[seg] : LEN_W'($urandom_range(0, 63));
      write_length(len);
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (i = 0; i < SEG_ITEMS; i++) send_word(random_word());
      wait_drained();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    if (encoder_checks.mismatches == 0 && encoder_checks.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
hdl/hev_pkg.sv
hdl/hev_front.sv
hdl/hev_place.sv
hdl/hev_parity.sv
hdl/hamming_encoder_variable_length.sv
hdl/hev_checker.sv
tb/tb_top.sv
